// ===== src/dts_pkg.sv =====
// Shared types, codes and constants of the DFS topological sort block.
`timescale 1ns / 1ps

package dts_pkg;

  localparam int IDX_W            = 6;
  localparam int CMD_W            = 2;
  localparam int S_TDATA_W        = 16;
  localparam int M_TDATA_W        = 8;
  localparam int M_TUSER_W        = 2;
  localparam int DEF_MAX_NODES    = 64;
  localparam int DEF_MAX_CHILDREN = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ENABLE = 2'd1,
    CMD_EDGE   = 2'd2,
    CMD_SORT   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_ROOT,
    ST_POP_RD,
    ST_POP_EVAL,
    ST_CNT,
    ST_CHILD,
    ST_EMIT,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic do_clear;
    logic do_enable;
    logic edge_lookup;
    logic edge_commit;
    logic sort_init;
    logic root_push;
    logic root_next;
    logic stack_rd;
    logic pop_drop;
    logic pop_finish;
    logic visit;
    logic child_first;
    logic child_step;
    logic emit_init;
    logic emit_rd;
    logic out_load;
    logic out_empty;
  } ctl_t;

  typedef struct packed {
    logic root_end;
    logic root_en;
    logic top_done;
    logic top_visited;
    logic sp_one;
    logic cnt_zero;
    logic child_more;
    logic done_zero;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/dts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dts_ctrl.sv =====
// Sequencer for graph loading, the DFS walk and result emission.
`timescale 1ns / 1ps

module dts_ctrl
  import dts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  cmd_e in_cmd_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_CLEAR:  ctl_o.do_clear = 1'b1;
            CMD_ENABLE: ctl_o.do_enable = 1'b1;
            CMD_EDGE: begin
              ctl_o.edge_lookup = 1'b1;
              state_d = ST_EDGE;
            end
            CMD_SORT: begin
              ctl_o.sort_init = 1'b1;
              state_d = ST_ROOT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_EDGE: begin
        ctl_o.edge_commit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_ROOT: begin
        if (sts_i.root_end) begin
          state_d = ST_EMIT;
        end else if (sts_i.root_en) begin
          ctl_o.root_push = 1'b1;
          state_d = ST_POP_RD;
        end else begin
          ctl_o.root_next = 1'b1;
        end
      end
      ST_POP_RD: begin
        ctl_o.stack_rd = 1'b1;
        state_d = ST_POP_EVAL;
      end
      ST_POP_EVAL: begin
        if (sts_i.top_done || sts_i.top_visited) begin
          ctl_o.pop_drop   = sts_i.top_done;
          ctl_o.pop_finish = !sts_i.top_done;
          if (sts_i.sp_one) begin
            ctl_o.root_next = 1'b1;
            state_d = ST_ROOT;
          end else begin
            state_d = ST_POP_RD;
          end
        end else begin
          ctl_o.visit = 1'b1;
          state_d = ST_CNT;
        end
      end
      ST_CNT: begin
        if (sts_i.cnt_zero) begin
          state_d = ST_POP_RD;
        end else begin
          ctl_o.child_first = 1'b1;
          state_d = ST_CHILD;
        end
      end
      ST_CHILD: begin
        ctl_o.child_step = 1'b1;
        if (!sts_i.child_more) begin
          state_d = ST_POP_RD;
        end
      end
      ST_EMIT: begin
        if (sts_i.done_zero) begin
          state_d = ST_EMPTY;
        end else begin
          ctl_o.emit_init = 1'b1;
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        if (sts_i.out_free) begin
          ctl_o.emit_rd = 1'b1;
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        ctl_o.out_load = 1'b1;
        state_d = sts_i.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          ctl_o.out_empty = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/dts_datapath.sv =====
// Graph storage, DFS stack, status flags, counters and output register.
`timescale 1ns / 1ps

module dts_datapath
  import dts_pkg::*;
#(
  parameter int MAX_NODES    = DEF_MAX_NODES,
  parameter int MAX_CHILDREN = DEF_MAX_CHILDREN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] node_index_i,
  input  logic [IDX_W-1:0] child_index_i,
  input  logic             enable_value_i,
  input  ctl_t             ctl_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] sorted_node_o,
  output logic             last_in_order_o,
  output logic             order_empty_o,
  output logic             edge_overflow_o
);

  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int SLOT_W      = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int CNT_W       = $clog2(MAX_CHILDREN + 1);
  localparam int CA_W        = NODE_W + SLOT_W;
  localparam int STACK_DEPTH = MAX_NODES * MAX_CHILDREN + 1;
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int DC_W        = $clog2(MAX_NODES + 1);

  logic [MAX_NODES-1:0] en_q, cvld_q, vis_q, fin_q;
  logic                 ovf_q;
  logic [NODE_W-1:0]    n_q, child_q;
  logic                 edge_ok_q;
  logic [DC_W-1:0]      root_q, dcnt_q, ecnt_q;
  logic [SP_W-1:0]      sp_q;
  logic [CNT_W-1:0]     ci_q, cnum_q;

  logic                 out_vld_q, out_last_q, out_empty_q, out_ovf_q;
  logic [IDX_W-1:0]     out_node_q;

  logic [NODE_W-1:0]    node_idx;
  logic                 in_ok;
  logic [CNT_W-1:0]     cnt_rd, cnt_cur;
  logic                 cnt_full, edge_wr;
  logic [NODE_W-1:0]    child_rd, top, fin_rd;
  logic                 child_new, push;
  logic [SP_W-1:0]      sp_m1;
  logic [DC_W-1:0]      ecnt_m1;
  logic [CNT_W-1:0]     ci_p1;
  logic [NODE_W-1:0]    cnt_raddr;
  logic [CA_W-1:0]      child_waddr, child_raddr;
  logic [NODE_W-1:0]    stk_wdata;

  assign node_idx = node_index_i[NODE_W-1:0];
  assign in_ok    = ({1'b0, node_index_i} < (IDX_W + 1)'(MAX_NODES))
                 && ({1'b0, child_index_i} < (IDX_W + 1)'(MAX_NODES));

  assign cnt_cur  = cvld_q[n_q] ? cnt_rd : '0;
  assign cnt_full = (cnt_cur >= CNT_W'(MAX_CHILDREN));
  assign edge_wr  = ctl_i.edge_commit && edge_ok_q && !cnt_full;

  assign child_new = !vis_q[child_rd] && !fin_q[child_rd];
  assign push      = (ctl_i.root_push || (ctl_i.child_step && child_new))
                  && (sp_q < SP_W'(STACK_DEPTH));
  assign stk_wdata = ctl_i.root_push ? root_q[NODE_W-1:0] : child_rd;
  assign sp_m1     = sp_q - SP_W'(1);
  assign ecnt_m1   = ecnt_q - DC_W'(1);
  assign ci_p1     = ci_q + CNT_W'(1);

  assign cnt_raddr   = ctl_i.visit ? top : node_idx;
  assign child_waddr = {n_q, cnt_cur[SLOT_W-1:0]};
  assign child_raddr = ctl_i.child_first ? {n_q, SLOT_W'(0)} : {n_q, ci_p1[SLOT_W-1:0]};

  dts_ram #(.Width(CNT_W), .Depth(MAX_NODES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (edge_wr),
    .waddr_i (n_q),
    .wdata_i (cnt_cur + CNT_W'(1)),
    .re_i    (ctl_i.edge_lookup || ctl_i.visit),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rd)
  );

  dts_ram #(.Width(NODE_W), .Depth(2 ** CA_W)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (edge_wr),
    .waddr_i (child_waddr),
    .wdata_i (child_q),
    .re_i    (ctl_i.child_first || (ctl_i.child_step && sts_o.child_more)),
    .raddr_i (child_raddr),
    .rdata_o (child_rd)
  );

  dts_ram #(.Width(NODE_W), .Depth(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (sp_q[SA_W-1:0]),
    .wdata_i (stk_wdata),
    .re_i    (ctl_i.stack_rd),
    .raddr_i (sp_m1[SA_W-1:0]),
    .rdata_o (top)
  );

  dts_ram #(.Width(NODE_W), .Depth(MAX_NODES)) u_fin_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.pop_finish),
    .waddr_i (dcnt_q[NODE_W-1:0]),
    .wdata_i (top),
    .re_i    (ctl_i.emit_rd),
    .raddr_i (ecnt_m1[NODE_W-1:0]),
    .rdata_o (fin_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= '0;
      cvld_q    <= '0;
      vis_q     <= '0;
      fin_q     <= '0;
      ovf_q     <= 1'b0;
      edge_ok_q <= 1'b0;
      root_q    <= '0;
      dcnt_q    <= '0;
      ecnt_q    <= '0;
      sp_q      <= '0;
      ci_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (ctl_i.do_clear) begin
        en_q   <= '0;
        cvld_q <= '0;
        ovf_q  <= 1'b0;
      end
      if (ctl_i.do_enable && ({1'b0, node_index_i} < (IDX_W + 1)'(MAX_NODES))) begin
        en_q[node_idx] <= enable_value_i;
      end
      if (ctl_i.edge_lookup) begin
        edge_ok_q <= in_ok;
      end
      if (ctl_i.edge_commit && edge_ok_q && cnt_full) begin
        ovf_q <= 1'b1;
      end
      if (edge_wr) begin
        cvld_q[n_q] <= 1'b1;
      end

      if (ctl_i.sort_init) begin
        vis_q  <= '0;
        fin_q  <= '0;
        root_q <= '0;
        dcnt_q <= '0;
        sp_q   <= '0;
      end else begin
        if (ctl_i.root_next) begin
          root_q <= root_q + DC_W'(1);
        end
        if (ctl_i.visit) begin
          vis_q[top] <= 1'b1;
        end
        if (ctl_i.pop_finish) begin
          fin_q[top] <= 1'b1;
          dcnt_q     <= dcnt_q + DC_W'(1);
        end
        if (push) begin
          sp_q <= sp_q + SP_W'(1);
        end else if (ctl_i.pop_drop || ctl_i.pop_finish) begin
          sp_q <= sp_m1;
        end
      end

      if (ctl_i.child_first) begin
        ci_q <= '0;
      end else if (ctl_i.child_step) begin
        ci_q <= ci_p1;
      end

      if (ctl_i.emit_init) begin
        ecnt_q <= dcnt_q;
      end else if (ctl_i.out_load) begin
        ecnt_q <= ecnt_m1;
      end

      if (ctl_i.out_load || ctl_i.out_empty) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.edge_lookup) begin
      n_q     <= node_idx;
      child_q <= child_index_i[NODE_W-1:0];
    end else if (ctl_i.visit) begin
      n_q <= top;
    end
    if (ctl_i.child_first) begin
      cnum_q <= cnt_cur;
    end
    if (ctl_i.out_load) begin
      out_node_q  <= IDX_W'(fin_rd);
      out_last_q  <= (ecnt_q == DC_W'(1));
      out_empty_q <= 1'b0;
      out_ovf_q   <= ovf_q;
    end else if (ctl_i.out_empty) begin
      out_node_q  <= '0;
      out_last_q  <= 1'b1;
      out_empty_q <= 1'b1;
      out_ovf_q   <= ovf_q;
    end
  end

  always_comb begin
    sts_o.root_end    = (root_q == DC_W'(MAX_NODES));
    sts_o.root_en     = en_q[root_q[NODE_W-1:0]];
    sts_o.top_done    = fin_q[top];
    sts_o.top_visited = vis_q[top];
    sts_o.sp_one      = (sp_q == SP_W'(1));
    sts_o.cnt_zero    = (cnt_cur == '0);
    sts_o.child_more  = (ci_p1 < cnum_q);
    sts_o.done_zero   = (dcnt_q == '0);
    sts_o.emit_last   = (ecnt_q == DC_W'(1));
    sts_o.out_free    = !out_vld_q || out_ready_i;
  end

  assign out_valid_o     = out_vld_q;
  assign sorted_node_o   = out_node_q;
  assign last_in_order_o = out_last_q;
  assign order_empty_o   = out_empty_q;
  assign edge_overflow_o = out_ovf_q;

endmodule

// ===== src/dfs_topological_sort.sv =====
// Top level of the DFS topological sort block.
//
// Input channel (s_axis): one beat per command. tuser carries the command
// (clear, enable node, append edge, sort); tdata carries node, child and
// enable bit. Clear and enable are done in the idle state; an edge append
// goes through a child count read, then a slot and count write.
// A sort clears the visit flags, then scans roots one node per cycle while
// no walk is running and walks the DFS stack held in RAM from each enabled
// root: each pop reads the stack top, then evaluates it, and a newly visited
// node has its child slots read one after another.
// Output channel (m_axis): nodes in topological order, each beat read
// from the finish-list RAM into the output register, tlast on the final
// node. An empty order gives a single beat with the empty flag in tuser.
// Commands are taken only while the sequencer is idle; the output register
// holds its beat while m_axis_tready is low and emission waits for it.
// Reset clears enables, child counts, the overflow flag and the sequencer;
// child list and stack RAM contents need no reset.
`timescale 1ns / 1ps

module dfs_topological_sort
  import dts_pkg::*;
#(
  parameter int MAX_NODES    = DEF_MAX_NODES,
  parameter int MAX_CHILDREN = DEF_MAX_CHILDREN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // node_index, child_index, enable_value
  input  logic [CMD_W-1:0]     s_axis_tuser,  // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // sorted_node
  output logic                 m_axis_tlast,  // last_in_order
  output logic [M_TUSER_W-1:0] m_axis_tuser   // order_empty, edge_overflow
);

  ctl_t             ctl;
  sts_t             sts;
  logic [IDX_W-1:0] sorted_node;
  logic             order_empty, edge_overflow;

  dts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (cmd_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  dts_datapath #(
    .MAX_NODES    (MAX_NODES),
    .MAX_CHILDREN (MAX_CHILDREN)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .node_index_i    (s_axis_tdata[IDX_W-1:0]),
    .child_index_i   (s_axis_tdata[2*IDX_W-1:IDX_W]),
    .enable_value_i  (s_axis_tdata[2*IDX_W]),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .sorted_node_o   (sorted_node),
    .last_in_order_o (m_axis_tlast),
    .order_empty_o   (order_empty),
    .edge_overflow_o (edge_overflow)
  );

  assign m_axis_tdata = M_TDATA_W'(sorted_node);
  assign m_axis_tuser = {edge_overflow, order_empty};

endmodule

// ===== tb/tb_dfs_topological_sort.sv =====
// Self-checking testbench for the DFS topological sort block with a graph predictor.
`timescale 1ns / 1ps

module tb_dfs_topological_sort;
  import dts_pkg::*;

  localparam int NODES       = DEF_MAX_NODES;
  localparam int SLOTS       = DEF_MAX_CHILDREN;
  localparam int HOLD_CYCLES = 1500;
  localparam int ITEM_TARGET = 400;
  localparam int DRAIN_WAIT  = 1200;

  typedef enum logic [1:0] {
    VS_NEW,
    VS_OPEN,
    VS_DONE
  } visit_e;

  typedef struct {
    logic [IDX_W-1:0] node;
    logic             last;
    logic             empty;
    logic             ovf;
  } order_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [CMD_W-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  logic [IDX_W-1:0] child_list [NODES][SLOTS];
  logic [3:0]       child_cnt  [NODES];
  logic             node_en    [NODES];
  logic             ovf_seen;

  order_beat_t expected_order [$];

  logic quiet      = 1'b0;
  logic hold_tgl   = 1'b0;
  logic hold_ack   = 1'b0;
  int   hold_left  = 0;
  int   fails      = 0;
  int   n_items    = 0;
  int   n_sorts    = 0;
  int   n_beats    = 0;
  int   n_ovf      = 0;
  int   n_empty    = 0;

  dfs_topological_sort u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Work out the emitted order of a sort from the current graph.
  function automatic void predict_order();
    visit_e           vstat    [NODES];
    logic [IDX_W-1:0] dfs_stack[NODES*SLOTS+1];
    logic [IDX_W-1:0] finished [NODES];
    int               sp;
    int               n_done;
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] kid;
    order_beat_t      beat;
    sp     = 0;
    n_done = 0;
    for (int n = 0; n < NODES; n++) vstat[n] = VS_NEW;
    for (int root = 0; root < NODES; root++) begin
      if (!node_en[root]) continue;
      dfs_stack[sp] = IDX_W'(root);
      sp++;
      while (sp > 0) begin
        top = dfs_stack[sp-1];
        if (vstat[top] == VS_DONE) begin
          sp--;
        end else if (vstat[top] == VS_OPEN) begin
          vstat[top] = VS_DONE;
          finished[n_done] = top;
          n_done++;
          sp--;
        end else begin
          vstat[top] = VS_OPEN;
          for (int i = 0; i < child_cnt[top]; i++) begin
            kid = child_list[top][i];
            if (vstat[kid] == VS_NEW) begin
              dfs_stack[sp] = kid;
              sp++;
            end
          end
        end
      end
    end
    n_sorts++;
    if (n_done == 0) begin
      beat = '{node: '0, last: 1'b1, empty: 1'b1, ovf: ovf_seen};
      expected_order.insert(expected_order.size(), beat);
    end else begin
      for (int i = n_done - 1; i >= 0; i--) begin
        beat = '{node: finished[i], last: (i == 0), empty: 1'b0, ovf: ovf_seen};
        expected_order.insert(expected_order.size(), beat);
      end
    end
  endfunction

  function automatic void update_graph(cmd_e cmd, logic [IDX_W-1:0] node,
                                       logic [IDX_W-1:0] child, logic en);
    case (cmd)
      CMD_CLEAR: begin
        for (int n = 0; n < NODES; n++) begin
          child_cnt[n] = '0;
          node_en[n]   = 1'b0;
        end
        ovf_seen = 1'b0;
      end
      CMD_ENABLE: begin
        node_en[node] = en;
      end
      CMD_EDGE: begin
        if (child_cnt[node] >= SLOTS) begin
          ovf_seen = 1'b1;
        end else begin
          child_list[node][child_cnt[node]] = child;
          child_cnt[node] = child_cnt[node] + 1'b1;
        end
      end
      default: begin
        predict_order();
      end
    endcase
  endfunction

  task automatic send_cmd(cmd_e cmd, logic [IDX_W-1:0] node = '0,
                          logic [IDX_W-1:0] child = '0, logic en = 1'b0);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 24) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, en, child, node};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    update_graph(cmd, node, child, en);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_order.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_after_reset();
    send_cmd(CMD_SORT);
  endtask

  task automatic test_small_dag();
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_ENABLE, 6'd0, 6'd0, 1'b1);
    send_cmd(CMD_EDGE, 6'd0, 6'd1);
    send_cmd(CMD_EDGE, 6'd0, 6'd2);
    send_cmd(CMD_EDGE, 6'd1, 6'd3);
    send_cmd(CMD_EDGE, 6'd2, 6'd3);
    send_cmd(CMD_SORT);
  endtask

  // Self loop, two-node cycle, disabled child, disabled root, top index.
  task automatic test_loops_and_enables();
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_ENABLE, 6'd5, 6'd0, 1'b1);
    send_cmd(CMD_ENABLE, 6'd9, 6'd0, 1'b1);
    send_cmd(CMD_ENABLE, 6'd9, 6'd0, 1'b0);
    send_cmd(CMD_EDGE, 6'd5, 6'd5);
    send_cmd(CMD_EDGE, 6'd5, 6'd6);
    send_cmd(CMD_EDGE, 6'd6, 6'd5);
    send_cmd(CMD_EDGE, 6'd6, 6'd9);
    send_cmd(CMD_ENABLE, 6'd63, 6'd0, 1'b1);
    send_cmd(CMD_EDGE, 6'd63, 6'd63);
    send_cmd(CMD_SORT);
  endtask

  task automatic test_slot_overflow();
    for (int i = 0; i <= SLOTS; i++) send_cmd(CMD_EDGE, 6'd62, 6'(63 - i));
    send_cmd(CMD_ENABLE, 6'd62, 6'd0, 1'b1);
    send_cmd(CMD_SORT);
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_SORT);
  endtask

  // Longest order: one chain through every node, with no idling.
  task automatic test_long_chain();
    wait_drained();
    quiet <= 1'b1;
    send_cmd(CMD_CLEAR);
    for (int n = 0; n < NODES - 1; n++) send_cmd(CMD_EDGE, 6'(n), 6'(n + 1));
    send_cmd(CMD_ENABLE, 6'd0, 6'd0, 1'b1);
    send_cmd(CMD_SORT);
    wait_drained();
    quiet <= 1'b0;
  endtask

  // Hold the output while the sender keeps offering commands.
  task automatic test_output_stall();
    hold_tgl <= ~hold_tgl;
    send_cmd(CMD_SORT);
    send_cmd(CMD_ENABLE, 6'd40, 6'd0, 1'b1);
    send_cmd(CMD_EDGE, 6'd40, 6'd12);
    send_cmd(CMD_SORT);
  endtask

  task automatic test_random_graphs();
    int               n_en;
    int               n_edge;
    int               span;
    logic [IDX_W-1:0] base;
    while (n_items < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 15) begin
        send_cmd(cmd_e'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 1'($urandom));
      end else begin
        span   = ($urandom_range(0, 2) == 0) ? 8 : NODES;
        base   = 6'($urandom);
        n_en   = $urandom_range(1, 6);
        n_edge = $urandom_range(0, 24);
        if ($urandom_range(0, 9) != 0) send_cmd(CMD_CLEAR);
        for (int i = 0; i < n_en; i++) begin
          send_cmd(CMD_ENABLE, base + 6'($urandom_range(0, span - 1)), 6'($urandom),
                   ($urandom_range(0, 4) != 0));
        end
        for (int i = 0; i < n_edge; i++) begin
          send_cmd(CMD_EDGE, base + 6'($urandom_range(0, span - 1)),
                   base + 6'($urandom_range(0, span - 1)), 1'($urandom));
        end
        send_cmd(CMD_SORT, 6'($urandom), 6'($urandom), 1'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_tgl != hold_ack) begin
      hold_ack      <= hold_tgl;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk_i) begin
    order_beat_t exp_beat;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_order.size() == 0) begin
        $error("unexpected beat: sorted_node %0d", m_axis_tdata[IDX_W-1:0]);
        fails++;
      end else begin
        exp_beat = expected_order.pop_front();
        n_beats++;
        if (m_axis_tuser[1]) n_ovf++;
        if (m_axis_tuser[0]) n_empty++;
        if (m_axis_tdata[IDX_W-1:0] !== exp_beat.node) begin
          $error("sorted_node: expected %0d, got %0d", exp_beat.node,
                 m_axis_tdata[IDX_W-1:0]);
          fails++;
        end
        if (m_axis_tlast !== exp_beat.last) begin
          $error("last_in_order: expected %0b, got %0b", exp_beat.last, m_axis_tlast);
          fails++;
        end
        if (m_axis_tuser[0] !== exp_beat.empty) begin
          $error("order_empty: expected %0b, got %0b", exp_beat.empty, m_axis_tuser[0]);
          fails++;
        end
        if (m_axis_tuser[1] !== exp_beat.ovf) begin
          $error("edge_overflow: expected %0b, got %0b", exp_beat.ovf, m_axis_tuser[1]);
          fails++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    for (int n = 0; n < NODES; n++) begin
      child_cnt[n] = '0;
      node_en[n]   = 1'b0;
    end
    ovf_seen      = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_CLEAR;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_after_reset();
    test_small_dag();
    test_loops_and_enables();
    test_slot_overflow();
    test_long_chain();
    test_output_stall();
    test_random_graphs();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("tb: %0d commands sent, %0d sorts, %0d order beats checked", n_items, n_sorts,
             n_beats);
    $display("tb: %0d empty orders, %0d beats with overflow flagged", n_empty, n_ovf);
    if (fails == 0 && expected_order.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dts_pkg.sv
src/dts_ram.sv
src/dts_ctrl.sv
src/dts_datapath.sv
src/dfs_topological_sort.sv
tb/tb_dfs_topological_sort.sv
